// ===== sv/agpc_pkg.sv =====
// ----------------------------------------------------------------------------
// agpc_pkg - shared types and constants of the gain / pot code converter
// item layouts, register codes, reset values and widths shared by the design and testbench
// ----------------------------------------------------------------------------
package agpc_pkg;

	// default pot code width
	localparam int CODE_BITS_DEF = 8;

	// feedback resistance width, also dividend and quotient width of the dividers
	localparam int RF_W = 20;

	// step resistance width, divisor width of the second divider
	localparam int STEP_W = 8;

	localparam int CFG_ADDR_W = 2;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_WIPER = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_STEP  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RF    = 2'd2;

	// reset values
	localparam logic [7:0]      WIPER_RST = 8'd72;
	localparam logic [7:0]      STEP_RST  = 8'd35;
	localparam logic [RF_W-1:0] RF_RST    = 20'd100000;

	localparam logic [15:0] GAIN_MAX = 16'hFFFF;

	// action codes
	localparam logic ACT_CODE_TO_GAIN = 1'b0;
	localparam logic ACT_GAIN_TO_CODE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [7:0]  pot_code_in;
		logic [15:0] requested_gain;
	} agpc_req_t;

	typedef struct packed {
		logic [15:0] gain_value;
		logic [7:0]  pot_code_out;
		logic        status;
	} agpc_rsp_t;

	typedef struct packed {
		logic [CFG_ADDR_W-1:0] addr;
		logic [RF_W-1:0]       wdata;
	} agpc_cfg_t;

	// per-item control that travels alongside the divider data
	typedef struct packed {
		logic        action;
		logic        err;   // divisor was zero
		logic        nul;   // code result forced to zero
		logic [15:0] gain;  // saturated gain, filled in after the first divider
	} agpc_side_t;

endpackage

// ===== sv/agpc_chan_if.sv =====
// ----------------------------------------------------------------------------
// agpc_chan_if - valid/ready channel
// carries one item of the given payload type per handshake
// ----------------------------------------------------------------------------
interface agpc_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/agpc_div_cell.sv =====
// ----------------------------------------------------------------------------
// agpc_div_cell - one restoring division cell
// retires one quotient bit and hands partial remainder to the next cell
// ----------------------------------------------------------------------------
module agpc_div_cell import agpc_pkg::*; #(
	parameter int NUM_W = RF_W,
	parameter int DEN_W = STEP_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [DEN_W-1:0] in_rem,
	input  agpc_side_t       in_side,
	output logic             out_valid,
	output logic [NUM_W-1:0] out_num,
	output logic [DEN_W-1:0] out_den,
	output logic [DEN_W-1:0] out_rem,
	output agpc_side_t       out_side
);
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic [DEN_W-1:0] rem_n;
	logic [NUM_W-1:0] num_n;
	logic             valid_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	agpc_side_t       side_q;

	// shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {in_rem, in_num[NUM_W-1]};
		diff  = trial - {1'b0, in_den};
		ge    = (trial >= {1'b0, in_den});
		rem_n = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		num_n = {in_num[NUM_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q  <= num_n;
			den_q  <= in_den;
			rem_q  <= rem_n;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_num   = num_q;
	assign out_den   = den_q;
	assign out_rem   = rem_q;
	assign out_side  = side_q;
endmodule

// ===== sv/agpc_div_chain.sv =====
// ----------------------------------------------------------------------------
// agpc_div_chain - row of division cells
// one cell per quotient bit, quotient replaces dividend as it shifts through
// ----------------------------------------------------------------------------
module agpc_div_chain import agpc_pkg::*; #(
	parameter int NUM_W = RF_W,
	parameter int DEN_W = STEP_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  agpc_side_t       in_side,
	output logic             out_valid,
	output logic [NUM_W-1:0] out_quo,
	output agpc_side_t       out_side
);
	logic             v_a    [NUM_W];
	logic [NUM_W-1:0] num_a  [NUM_W];
	logic [DEN_W-1:0] den_a  [NUM_W];
	logic [DEN_W-1:0] rem_a  [NUM_W];
	agpc_side_t       side_a [NUM_W];

	assign v_a[0]    = in_valid;
	assign num_a[0]  = in_num;
	assign den_a[0]  = in_den;
	assign rem_a[0]  = '0;
	assign side_a[0] = in_side;

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		if (i < NUM_W - 1) begin : g_mid
			agpc_div_cell #(
				.NUM_W (NUM_W),
				.DEN_W (DEN_W)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (v_a[i]),
				.in_num    (num_a[i]),
				.in_den    (den_a[i]),
				.in_rem    (rem_a[i]),
				.in_side   (side_a[i]),
				.out_valid (v_a[i+1]),
				.out_num   (num_a[i+1]),
				.out_den   (den_a[i+1]),
				.out_rem   (rem_a[i+1]),
				.out_side  (side_a[i+1])
			);
		end else begin : g_last
			// remainder and divisor are not needed past the last cell
			agpc_div_cell #(
				.NUM_W (NUM_W),
				.DEN_W (DEN_W)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (v_a[i]),
				.in_num    (num_a[i]),
				.in_den    (den_a[i]),
				.in_rem    (rem_a[i]),
				.in_side   (side_a[i]),
				.out_valid (out_valid),
				.out_num   (out_quo),
				.out_den   (),
				.out_rem   (),
				.out_side  (out_side)
			);
		end
	end
endmodule

// ===== sv/amp_gain_pot_code_converter_unit.sv =====
// ----------------------------------------------------------------------------
// amp_gain_pot_code_converter_unit - gain / digital pot code converter
// turns a pot code into amplifier gain 1 + Rf/Rg, or a requested gain into
// the pot code that sets Rg, using two rows of pipelined division cells
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                   accepted when
//  req      in   action, pot_code_in, requested_gain       req.valid && req.ready
//  rsp      out  gain_value, pot_code_out, status          rsp.valid && rsp.ready
//  cfg      in   addr (register index), wdata              cfg.valid && cfg.ready
//
//  one item per cycle sustained while rsp is not stalled; on its way to
//  rsp.valid an item goes through the prep stage, loaded by the accepting edge,
//  then 20 cells of the Rf divider, mid stage, 20 cells of the step divider and
//  the output register
//  reset clears all valid bits and loads the register reset values
//  an rsp stall freezes the pipeline; an empty prep stage still takes an item
//  cfg is always ready, writes are expected only while no item is in flight
//
module amp_gain_pot_code_converter_unit import agpc_pkg::*; #(
	parameter int CODE_BITS = CODE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	agpc_chan_if.sink   req,
	agpc_chan_if.source rsp,
	agpc_chan_if.sink   cfg
);
	// widths and limits that follow from the code width
	localparam int RG_W   = CODE_BITS + 8;            // wiper + steps * step
	localparam int DIVR_W = (RG_W > 16) ? RG_W : 16;  // first divisor
	localparam int CW     = (CODE_BITS > 8) ? CODE_BITS : 8;
	localparam logic [CODE_BITS-1:0] CODE_MAX = '1;
	localparam int OUT_MAX_I = (CODE_BITS < 8) ? ((1 << CODE_BITS) - 1) : 255;
	localparam logic [7:0] OUT_MAX = OUT_MAX_I[7:0];

	// configuration registers
	logic [7:0]      wiper_q;
	logic [7:0]      step_q;
	logic [RF_W-1:0] rf_q;

	// global advance: the output register is free or being emptied
	logic adv;
	logic take_req;

	// prep stage
	logic [CW-1:0]        code_ext;
	logic [CW-1:0]        code_c;
	logic [CODE_BITS-1:0] diff_c;
	logic [RG_W-1:0]      rg0;
	logic [15:0]          gm1;
	agpc_side_t           side_n;
	logic [DIVR_W-1:0]    den_n;

	logic              v_s1;
	logic [RF_W-1:0]   num_s1;
	logic [DIVR_W-1:0] den_s1;
	agpc_side_t        side_s1;

	// first divider row: Rf / Rg or Rf / (G - 1)
	logic            v1;
	logic [RF_W-1:0] q1;
	agpc_side_t      side1;

	// mid stage
	agpc_side_t      side_m;
	logic [RF_W-1:0] num_m;

	logic              v_s2;
	logic [RF_W-1:0]   num_s2;
	logic [STEP_W-1:0] den_s2;
	agpc_side_t        side_s2;

	// second divider row: (Rg - wiper) / step
	logic            v2;
	logic [RF_W-1:0] q2;
	agpc_side_t      side2;

	// output register
	logic      rsp_valid_q;
	agpc_rsp_t rsp_q;
	agpc_rsp_t rsp_n;

	assign adv      = !rsp_valid_q || rsp.ready;
	assign take_req = adv || !v_s1;

	assign req.ready = take_req;
	assign cfg.ready = 1'b1;

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiper_q <= WIPER_RST;
			step_q  <= STEP_RST;
			rf_q    <= RF_RST;
		end else if (cfg.valid) begin
			unique case (cfg.payload.addr)
				REG_WIPER: wiper_q <= cfg.payload.wdata[7:0];
				REG_STEP:  step_q  <= cfg.payload.wdata[7:0];
				REG_RF:    rf_q    <= cfg.payload.wdata;
				default: begin
				end
			endcase
		end
	end

	// prep: clamp code, build Rg or G - 1, flag zero divisors
	always_comb begin
		code_ext = CW'(req.payload.pot_code_in);
		code_c   = (code_ext > CW'(CODE_MAX)) ? CW'(CODE_MAX) : code_ext;
		diff_c   = CODE_MAX - code_c[CODE_BITS-1:0];
		rg0      = RG_W'(diff_c) * RG_W'(step_q) + RG_W'(wiper_q);
		gm1      = req.payload.requested_gain - 16'd1;

		side_n.action = req.payload.action;
		side_n.gain   = '0;
		unique case (req.payload.action)
			ACT_CODE_TO_GAIN: begin
				side_n.err = (rg0 == '0);
				side_n.nul = 1'b0;
				den_n      = DIVR_W'(rg0);
			end
			ACT_GAIN_TO_CODE: begin
				side_n.err = (req.payload.requested_gain == 16'd1) || (step_q == '0);
				side_n.nul = (req.payload.requested_gain == 16'd0);
				den_n      = DIVR_W'(gm1);
			end
			default: begin
				side_n.err = 1'b0;
				side_n.nul = 1'b0;
				den_n      = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take_req) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			num_s1  <= rf_q;
			den_s1  <= den_n;
			side_s1 <= side_n;
		end
	end

	agpc_div_chain #(
		.NUM_W (RF_W),
		.DEN_W (DIVR_W)
	) u_div_rg (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s1),
		.in_num    (num_s1),
		.in_den    (den_s1),
		.in_side   (side_s1),
		.out_valid (v1),
		.out_quo   (q1),
		.out_side  (side1)
	);

	// mid: saturate gain, subtract wiper for the code path
	always_comb begin
		side_m      = side1;
		side_m.gain = (q1 >= RF_W'(GAIN_MAX)) ? GAIN_MAX : (q1[15:0] + 16'd1);
		// target below the wiper gives code zero
		if (side1.action == ACT_GAIN_TO_CODE && q1 < RF_W'(wiper_q)) begin
			side_m.nul = 1'b1;
		end
		num_m = q1 - RF_W'(wiper_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2  <= num_m;
			den_s2  <= step_q;
			side_s2 <= side_m;
		end
	end

	agpc_div_chain #(
		.NUM_W (RF_W),
		.DEN_W (STEP_W)
	) u_div_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s2),
		.in_num    (num_s2),
		.in_den    (den_s2),
		.in_side   (side_s2),
		.out_valid (v2),
		.out_quo   (q2),
		.out_side  (side2)
	);

	// result: unused field and error cases read zero
	always_comb begin
		rsp_n.status = side2.err;
		rsp_n.gain_value = (side2.action == ACT_CODE_TO_GAIN && !side2.err)
			? side2.gain : 16'd0;
		if (side2.action == ACT_GAIN_TO_CODE && !side2.err && !side2.nul) begin
			rsp_n.pot_code_out = (q2 > RF_W'(OUT_MAX)) ? OUT_MAX : q2[7:0];
		end else begin
			rsp_n.pot_code_out = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// an error leaves both result fields at zero
	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.status |->
			rsp.payload.gain_value == 16'd0 && rsp.payload.pot_code_out == 8'd0)
		else $error("error result with nonzero field");

	// only one of the two result fields can carry a value
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.payload.gain_value == 16'd0 || rsp.payload.pot_code_out == 8'd0)
		else $error("both result fields nonzero");

	// code result respects the clamp
	a_code_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.payload.pot_code_out <= OUT_MAX)
		else $error("pot code above clamp");

	// a stall freezes the mid stage with its data
	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv |=> v_s2 && $stable(num_s2) && $stable(side_s2))
		else $error("mid stage changed during stall");
endmodule

// ===== dv/agpc_gain_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// agpc_gain_checker - result checker of the gain / pot code converter
// tracks register writes, predicts the result of every accepted item and
// compares each accepted result with the oldest prediction
// ----------------------------------------------------------------------------
module agpc_gain_checker import agpc_pkg::*; #(
	parameter int CODE_BITS = CODE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  agpc_req_t req_item,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  agpc_rsp_t rsp_item,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  agpc_cfg_t cfg_item,
	output int        mismatches,
	output int        in_flight
);

	localparam logic [31:0] CODE_MAX     = (32'd1 << CODE_BITS) - 32'd1;
	localparam logic [31:0] CODE_OUT_MAX = 32'd255;

	logic [7:0]      wiper_ohm;
	logic [7:0]      step_ohm;
	logic [RF_W-1:0] rf_ohm;

	agpc_rsp_t conversions_q[$];
	agpc_rsp_t oldest;
	int        error_total = 0;

	function automatic agpc_rsp_t predict_conversion(agpc_req_t item);
		agpc_rsp_t   res;
		logic [31:0] code;
		logic [31:0] rg;
		logic [31:0] gain;
		logic [31:0] g;
		res = '0;
		if (item.action == ACT_CODE_TO_GAIN) begin
			code = (item.pot_code_in > CODE_MAX) ? CODE_MAX : 32'(item.pot_code_in);
			rg = 32'(wiper_ohm) + (CODE_MAX - code) * 32'(step_ohm);
			if (rg == 0) begin
				res.status = 1'b1;
			end else begin
				gain = 32'd1 + 32'(rf_ohm) / rg;
				res.gain_value = (gain > 32'(GAIN_MAX)) ? GAIN_MAX : gain[15:0];
			end
		end else begin
			g = 32'(item.requested_gain);
			if (g == 32'd1 || step_ohm == 0) begin
				res.status = 1'b1;
			end else if (g != 0) begin
				rg = 32'(rf_ohm) / (g - 32'd1);
				// target below the wiper leaves the code at zero
				if (rg >= 32'(wiper_ohm)) begin
					code = (rg - 32'(wiper_ohm)) / 32'(step_ohm);
					if (code > CODE_MAX)
						code = CODE_MAX;
					if (code > CODE_OUT_MAX)
						code = CODE_OUT_MAX;
					res.pot_code_out = code[7:0];
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiper_ohm = WIPER_RST;
			step_ohm  = STEP_RST;
			rf_ohm    = RF_RST;
			conversions_q.delete();
			mismatches <= error_total;
			in_flight  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_item.addr)
					REG_WIPER: wiper_ohm = cfg_item.wdata[7:0];
					REG_STEP:  step_ohm  = cfg_item.wdata[7:0];
					REG_RF:    rf_ohm    = cfg_item.wdata;
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (conversions_q.size() == 0) begin
					$error("unexpected result: gain_value %0d pot_code_out %0d status %0d",
						rsp_item.gain_value, rsp_item.pot_code_out, rsp_item.status);
					error_total++;
				end else begin
					oldest = conversions_q.pop_front();
					if (rsp_item.gain_value !== oldest.gain_value) begin
						$error("gain_value mismatch: expected %0d, actual %0d",
							oldest.gain_value, rsp_item.gain_value);
						error_total++;
					end
					if (rsp_item.pot_code_out !== oldest.pot_code_out) begin
						$error("pot_code_out mismatch: expected %0d, actual %0d",
							oldest.pot_code_out, rsp_item.pot_code_out);
						error_total++;
					end
					if (rsp_item.status !== oldest.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							oldest.status, rsp_item.status);
						error_total++;
					end
				end
			end
			if (req_valid && req_ready)
				conversions_q.push_back(predict_conversion(req_item));
			mismatches <= error_total;
			in_flight  <= conversions_q.size();
		end
	end

endmodule

// ===== dv/amp_gain_pot_code_converter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// amp_gain_pot_code_converter_unit_tb - testbench of the gain / pot converter
// drives directed corner items and random conversions over several register
// settings with random idling and one long result hold-off; a side checker
// predicts every result and the top reports the verdict
// ----------------------------------------------------------------------------
module amp_gain_pot_code_converter_unit_tb import agpc_pkg::*;;

	// unmapped register index, writes to it must be ignored
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int NO_IDLE_PHASE   = 3;
	localparam int HOLD_PHASE      = 5;
	localparam int HOLD_CYCLES     = 300;
	// pipeline is 43 deep, give the tail some margin
	localparam int TAIL_CYCLES     = 60;

	logic clk = 1'b0;
	logic arst_n;

	// idling switches for sender and receiver
	bit req_gaps = 1'b1;
	bit rsp_gaps = 1'b1;

	// hold-off request for the receiver, and its own countdown
	int hold_request = 0;
	int hold_left    = 0;

	int mismatches;
	int in_flight;

	agpc_chan_if #(.payload_t(agpc_req_t)) req_if ();
	agpc_chan_if #(.payload_t(agpc_rsp_t)) rsp_if ();
	agpc_chan_if #(.payload_t(agpc_cfg_t)) cfg_if ();

	always #5 clk = ~clk;

	amp_gain_pot_code_converter_unit #(
		.CODE_BITS(CODE_BITS_DEF)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	agpc_gain_checker #(
		.CODE_BITS(CODE_BITS_DEF)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_if.valid),
		.req_ready  (req_if.ready),
		.req_item   (req_if.payload),
		.rsp_valid  (rsp_if.valid),
		.rsp_ready  (rsp_if.ready),
		.rsp_item   (rsp_if.payload),
		.cfg_valid  (cfg_if.valid),
		.cfg_ready  (cfg_if.ready),
		.cfg_item   (cfg_if.payload),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	// result side: random stalls, or a long hold-off when asked for
	always @(posedge clk) begin
		if (hold_left == 0 && hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			rsp_if.ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_if.ready <= !rsp_gaps || ($urandom_range(99) >= 23);
		end
	end

	function automatic agpc_req_t make_item(logic act, logic [7:0] code, logic [15:0] gain);
		agpc_req_t item;
		item.action         = act;
		item.pot_code_in    = code;
		item.requested_gain = gain;
		return item;
	endfunction

	// gains partly in 2..2000, some tiny, some across the full 16-bit range
	function automatic agpc_req_t random_item();
		agpc_req_t item;
		item.action = 1'($urandom_range(1));
		case ($urandom_range(9))
			0:       item.pot_code_in = $urandom_range(1) ? 8'd255 : 8'd0;
			default: item.pot_code_in = 8'($urandom_range(255));
		endcase
		case ($urandom_range(9))
			0, 1:          item.requested_gain = 16'($urandom_range(3));
			2, 3, 4, 5:    item.requested_gain = 16'($urandom_range(2000, 2));
			default:       item.requested_gain = 16'($urandom_range(65535));
		endcase
		return item;
	endfunction

	// register values biased toward their extremes
	function automatic logic [RF_W-1:0] pick_value(logic [RF_W-1:0] lo, logic [RF_W-1:0] hi);
		case ($urandom_range(3))
			0:       return lo;
			1:       return hi;
			default: return RF_W'($urandom_range(hi, lo));
		endcase
	endfunction

	// offer one item, optionally after some idle cycles; valid stays high afterwards
	task automatic put_req(agpc_req_t item);
		if (req_gaps) begin
			while ($urandom_range(99) < 23) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= item;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic cfg_put(logic [CFG_ADDR_W-1:0] addr, logic [RF_W-1:0] data);
		agpc_cfg_t wr;
		wr.addr  = addr;
		wr.wdata = data;
		cfg_if.valid   <= 1'b1;
		cfg_if.payload <= wr;
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	// back-to-back writes, with a junk write to the unmapped index first
	task automatic set_regs(logic [7:0] wiper, logic [7:0] step, logic [RF_W-1:0] rf);
		cfg_put(REG_UNUSED, RF_W'($urandom_range(20'hFFFFF)));
		cfg_put(REG_WIPER, RF_W'(wiper));
		cfg_put(REG_STEP, RF_W'(step));
		cfg_put(REG_RF, rf);
		cfg_if.valid <= 1'b0;
	endtask

	// stop offering and wait until every accepted item has come back
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n         <= 1'b0;
		req_if.valid   <= 1'b0;
		req_if.payload <= '0;
		cfg_if.valid   <= 1'b0;
		cfg_if.payload <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: code extremes, unused fields full of junk
		put_req(make_item(ACT_CODE_TO_GAIN, 8'd0,   16'hFFFF));
		put_req(make_item(ACT_CODE_TO_GAIN, 8'd255, 16'h0000));
		put_req(make_item(ACT_CODE_TO_GAIN, 8'd1,   16'hA5A5));
		put_req(make_item(ACT_CODE_TO_GAIN, 8'd128, 16'h5A5A));
		// gain of zero, gain of one, two code clamps, normal, target below wiper, max gain
		put_req(make_item(ACT_GAIN_TO_CODE, 8'hFF, 16'd0));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'hFF, 16'd1));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'h00, 16'd2));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'h5A, 16'd3));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'hA5, 16'd100));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'h00, 16'd5000));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'hFF, 16'd65535));
		drain();

		// zero wiper and zero step: zero gain resistor, zero divisor in the code path
		set_regs(8'd0, 8'd0, 20'hFFFFF);
		put_req(make_item(ACT_CODE_TO_GAIN, 8'd255, 16'd7));
		put_req(make_item(ACT_CODE_TO_GAIN, 8'd0,   16'd7));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'd3,   16'd10));
		drain();

		// one ohm per step: gain saturation and large code clamp
		set_regs(8'd0, 8'd1, 20'hFFFFF);
		put_req(make_item(ACT_CODE_TO_GAIN, 8'd254, 16'd0));
		put_req(make_item(ACT_CODE_TO_GAIN, 8'd255, 16'd0));
		put_req(make_item(ACT_CODE_TO_GAIN, 8'd0,   16'd0));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'd0,   16'd2));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'd0,   16'd65535));
		drain();

		// largest wiper and step with the smallest feedback resistance
		set_regs(8'd255, 8'd255, 20'd1);
		put_req(make_item(ACT_CODE_TO_GAIN, 8'd0, 16'd0));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'd0, 16'd2));
		put_req(make_item(ACT_GAIN_TO_CODE, 8'd0, 16'd0));
		drain();

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				set_regs(WIPER_RST, STEP_RST, RF_RST);
			else
				set_regs(8'(pick_value(20'd0, 20'd255)), 8'(pick_value(20'd0, 20'd255)),
					pick_value(20'd1, 20'hFFFFF));
			req_gaps = (ph != NO_IDLE_PHASE);
			rsp_gaps = (ph != NO_IDLE_PHASE);
			// receiver sits still while items keep coming, so the pipe backs up
			if (ph == HOLD_PHASE)
				hold_request = HOLD_CYCLES;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				put_req(random_item());
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("amp_gain_pot_code_converter_unit_tb: done, clean");
		else
			$display("amp_gain_pot_code_converter_unit_tb: done, errors");
		$finish;
	end

	// overall run limit
	initial begin
		#2_000_000;
		$display("amp_gain_pot_code_converter_unit_tb: done, errors");
		$finish;
	end

endmodule
